/* rtl/core/adsr_pkg.sv */
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types and constants of the linear ADSR envelope generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int LEVEL_W   = 24;
    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 23;
    localparam int DIV_STEPS = 24;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } stage_t;

    typedef enum logic [1:0] {
        REQ_SAMPLE   = 2'd0,
        REQ_NOTE_ON  = 2'd1,
        REQ_NOTE_OFF = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        REG_ATTACK_STEP     = 2'd0,
        REG_DECAY_STEP      = 2'd1,
        REG_SUSTAIN_LEVEL   = 2'd2,
        REG_RELEASE_SAMPLES = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic sample_step;
        logic note_on;
        logic go_idle;
        logic div_load;
        logic div_step;
        logic div_fin;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic stage_idle;
        logic release_zero;
    } ctrl_status_t;

endpackage

/* rtl/core/adsr_ctrl.sv */
// ----------------------------------------------------------------------------
// adsr_ctrl
// Sequencer: request decode, release divider stepping, output word handshake.
// ----------------------------------------------------------------------------
module adsr_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [1:0]              req_type,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  adsr_pkg::ctrl_status_t  status,
    output adsr_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCALE = 2'd1,
        S_DIV   = 2'd2,
        S_FIN   = 2'd3
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [adsr_pkg::CNT_W-1:0]   cnt_reg;
    logic [adsr_pkg::CNT_W-1:0]   cnt_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         accept;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        adsr_pkg::REQ_SAMPLE:
                        begin
                            cmd.sample_step = 1'b1;
                            state_next      = S_SCALE;
                        end
                        adsr_pkg::REQ_NOTE_ON:
                        begin
                            cmd.note_on = 1'b1;
                        end
                        adsr_pkg::REQ_NOTE_OFF:
                        begin
                            if (!status.stage_idle)
                            begin
                                if (status.release_zero)
                                begin
                                    cmd.go_idle = 1'b1;
                                end
                                else
                                begin
                                    cmd.div_load = 1'b1;
                                    cnt_next     = '0;
                                    state_next   = S_DIV;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCALE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == adsr_pkg::CNT_W'(adsr_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.div_fin = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/adsr_dp.sv */
// ----------------------------------------------------------------------------
// adsr_dp
// Datapath: configuration registers, envelope state, restoring divider for
// the release step, sample scaler and output word register.
// ----------------------------------------------------------------------------
module adsr_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [1:0]                            cfg_index,
    input  logic [adsr_pkg::LEVEL_W-1:0]          cfg_data,
    input  logic signed [adsr_pkg::SAMPLE_W-1:0]  sample_in,
    input  adsr_pkg::ctrl_cmd_t                   cmd,
    output adsr_pkg::ctrl_status_t                status,
    output logic signed [adsr_pkg::SAMPLE_W-1:0]  sample_out,
    output logic [adsr_pkg::LEVEL_W-1:0]          level_out,
    output logic [2:0]                            stage_out
);

    localparam int LW = adsr_pkg::LEVEL_W;
    localparam int SW = adsr_pkg::SAMPLE_W;
    localparam int PW = SW + LW + 1;

    logic [LW-1:0]          attack_reg,  attack_next;
    logic [LW-1:0]          decay_reg,   decay_next;
    logic [LW-1:0]          sustain_reg, sustain_next;
    logic [LW-1:0]          rel_cnt_reg, rel_cnt_next;

    adsr_pkg::stage_t       stage_reg,   stage_next;
    logic [LW-1:0]          level_reg,   level_next;
    logic [LW-1:0]          rel_step_reg, rel_step_next;

    logic signed [SW-1:0]   sample_reg,  sample_next;
    logic [LW:0]            rem_reg,     rem_next;
    logic [LW-1:0]          quo_reg,     quo_next;
    logic signed [SW-1:0]   out_sample_reg, out_sample_next;
    logic [LW-1:0]          out_level_reg,  out_level_next;
    adsr_pkg::stage_t       out_stage_reg,  out_stage_next;

    logic [LW-1:0]          sus_sat;
    logic [LW:0]            att_sum;
    logic signed [LW+1:0]   dec_diff;
    logic signed [LW+1:0]   rel_diff;
    logic [LW:0]            div_shift;
    logic [LW+1:0]          div_trial;
    logic signed [PW-1:0]   product;

    assign sus_sat   = (sustain_reg > adsr_pkg::FULL_SCALE) ? adsr_pkg::FULL_SCALE : sustain_reg;
    assign att_sum   = {1'b0, level_reg} + {1'b0, attack_reg};
    assign dec_diff  = $signed({2'b00, level_reg}) - $signed({2'b00, decay_reg});
    assign rel_diff  = $signed({2'b00, level_reg}) - $signed({2'b00, rel_step_reg});
    assign div_shift = {rem_reg[LW-1:0], quo_reg[LW-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, rel_cnt_reg};
    assign product   = PW'($signed(sample_reg)) * PW'($signed({1'b0, level_reg}));

    assign status.stage_idle   = (stage_reg == adsr_pkg::ST_IDLE);
    assign status.release_zero = (rel_cnt_reg == '0);

    assign sample_out = out_sample_reg;
    assign level_out  = out_level_reg;
    assign stage_out  = out_stage_reg;

    always_comb
    begin
        attack_next     = attack_reg;
        decay_next      = decay_reg;
        sustain_next    = sustain_reg;
        rel_cnt_next    = rel_cnt_reg;
        stage_next      = stage_reg;
        level_next      = level_reg;
        rel_step_next   = rel_step_reg;
        sample_next     = sample_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        out_sample_next = out_sample_reg;
        out_level_next  = out_level_reg;
        out_stage_next  = out_stage_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                adsr_pkg::REG_ATTACK_STEP:     attack_next  = cfg_data;
                adsr_pkg::REG_DECAY_STEP:      decay_next   = cfg_data;
                adsr_pkg::REG_SUSTAIN_LEVEL:   sustain_next = cfg_data;
                adsr_pkg::REG_RELEASE_SAMPLES: rel_cnt_next = cfg_data;
                default:
                begin
                end
            endcase
        end

        if (cmd.sample_step)
        begin
            sample_next = sample_in;
            case (stage_reg)
                adsr_pkg::ST_ATTACK:
                begin
                    if (att_sum >= {1'b0, adsr_pkg::FULL_SCALE})
                    begin
                        level_next = adsr_pkg::FULL_SCALE;
                        stage_next = (decay_reg != '0) ? adsr_pkg::ST_DECAY
                                                       : adsr_pkg::ST_SUSTAIN;
                    end
                    else
                    begin
                        level_next = att_sum[LW-1:0];
                    end
                end
                adsr_pkg::ST_DECAY:
                begin
                    if (dec_diff <= $signed({2'b00, sus_sat}))
                    begin
                        level_next = sus_sat;
                        stage_next = adsr_pkg::ST_SUSTAIN;
                    end
                    else
                    begin
                        level_next = dec_diff[LW-1:0];
                    end
                end
                adsr_pkg::ST_SUSTAIN:
                begin
                    level_next = sus_sat;
                end
                adsr_pkg::ST_RELEASE:
                begin
                    if (rel_diff <= $signed({(LW+2){1'b0}}))
                    begin
                        level_next = '0;
                        stage_next = adsr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        level_next = rel_diff[LW-1:0];
                    end
                end
                default:
                begin
                    level_next = '0;
                    stage_next = adsr_pkg::ST_IDLE;
                end
            endcase
        end

        if (cmd.note_on)
        begin
            if (attack_reg != '0)
            begin
                stage_next = adsr_pkg::ST_ATTACK;
            end
            else if (decay_reg != '0)
            begin
                level_next = adsr_pkg::FULL_SCALE;
                stage_next = adsr_pkg::ST_DECAY;
            end
            else
            begin
                level_next = sus_sat;
                stage_next = adsr_pkg::ST_SUSTAIN;
            end
        end

        if (cmd.go_idle)
        begin
            level_next = '0;
            stage_next = adsr_pkg::ST_IDLE;
        end

        if (cmd.div_load)
        begin
            rem_next = '0;
            quo_next = level_reg;
        end

        if (cmd.div_step)
        begin
            rem_next = div_trial[LW+1] ? div_shift : div_trial[LW:0];
            quo_next = {quo_reg[LW-2:0], ~div_trial[LW+1]};
        end

        if (cmd.div_fin)
        begin
            rel_step_next = (quo_reg == '0) ? LW'(1) : quo_reg;
            stage_next    = adsr_pkg::ST_RELEASE;
        end

        if (cmd.out_load)
        begin
            out_sample_next = (stage_reg == adsr_pkg::ST_IDLE) ? '0
                            : product[adsr_pkg::FRAC_BITS +: SW];
            out_level_next  = level_reg;
            out_stage_next  = stage_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg   <= '0;
            decay_reg    <= '0;
            sustain_reg  <= '0;
            rel_cnt_reg  <= '0;
            stage_reg    <= adsr_pkg::ST_IDLE;
            level_reg    <= '0;
            rel_step_reg <= '0;
        end
        else
        begin
            attack_reg   <= attack_next;
            decay_reg    <= decay_next;
            sustain_reg  <= sustain_next;
            rel_cnt_reg  <= rel_cnt_next;
            stage_reg    <= stage_next;
            level_reg    <= level_next;
            rel_step_reg <= rel_step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg     <= sample_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        out_sample_reg <= out_sample_next;
        out_level_reg  <= out_level_next;
        out_stage_reg  <= out_stage_next;
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_fin |=> (stage_reg == adsr_pkg::ST_RELEASE) && (rel_step_reg != '0))
    else $error("release step not armed after division");

    assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= adsr_pkg::FULL_SCALE)
    else $error("envelope level above full scale");

    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg == adsr_pkg::ST_IDLE) |-> (level_reg == '0))
    else $error("nonzero level while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> $stable(level_reg) && $stable(rel_cnt_reg))
    else $error("divider operands changed during division");
`endif

endmodule

/* rtl/core/adsr_envelope_generator_top.sv */
// ----------------------------------------------------------------------------
// adsr_envelope_generator_top
// Linear ADSR envelope applied to a 16-bit audio stream.
// ----------------------------------------------------------------------------
// An audio sample holds the input side until its output word loads: the
// envelope steps at the accepting edge and the scaled output word loads at the
// next edge, later only while the previous output word still waits for m_tready.
// A note-on, an unused request code, and a note-off while idle or with
// release_samples at zero leave the input side ready and yield no word. A
// note-off that starts a release loads the restoring divider, which forms
// level / release_samples one quotient bit per cycle, and then arms the release.
// Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_in
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] sample_out, [39:16] level_out
    output logic [2:0]  m_tuser    // [2:0] stage_out
);

    adsr_pkg::ctrl_cmd_t     cmd;
    adsr_pkg::ctrl_status_t  status;
    logic signed [15:0]      sample_out;
    logic [23:0]             level_out;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {level_out, sample_out};

    adsr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    adsr_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (s_tdata),
        .cmd        (cmd),
        .status     (status),
        .sample_out (sample_out),
        .level_out  (level_out),
        .stage_out  (m_tuser)
    );

endmodule
